// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define RCT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// implication form on top of the plain one
`define RCT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  `RCT_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

// ===== design/rct_pkg.sv =====
// shared types and constants of the chunk tracker
`default_nettype none

package rct_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int MAX_RESULTS    = 8;

  localparam logic [31:0] INIT_SEND_RST  = 32'd1;
  localparam logic [15:0] RESEND_IVL_RST = 16'd200;

  // register indexes
  localparam logic REG_INIT_SEND  = 1'b0;
  localparam logic REG_RESEND_IVL = 1'b1;

  // input actions
  localparam logic [2:0] ACT_OPEN = 3'd0;
  localparam logic [2:0] ACT_SEND = 3'd1;
  localparam logic [2:0] ACT_TICK = 3'd2;
  localparam logic [2:0] ACT_ACK  = 3'd3;
  localparam logic [2:0] ACT_DATA = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_REGISTERED = 3'd0;
  localparam logic [2:0] KIND_FULL       = 3'd1;
  localparam logic [2:0] KIND_RESEND     = 3'd2;
  localparam logic [2:0] KIND_ACK_ACCEPT = 3'd3;
  localparam logic [2:0] KIND_ACK_DROP   = 3'd4;
  localparam logic [2:0] KIND_ACK_DONE   = 3'd5;

  typedef struct packed {
    logic load_item;
    logic do_open;
    logic do_send;
    logic do_data;
    logic time_inc;
    logic scan_clear;
    logic scan_read;
    logic tick_eval;
    logic ack_eval;
    logic scan_next;
    logic ack_result;
    logic finalize;
  } rct_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       tick_hit;
    logic       hits_full;
    logic       scan_last;
    logic       pend_valid;
    logic       out_busy;
  } rct_status_t;

endpackage

`default_nettype wire

// ===== design/reliable_chunk_tracker_top.sv =====
// open updates the state with no result; send and data load the pending result register,
// which the final state pushes to the result beat; tick and ack scan the table slot by slot
// with a read state and an evaluate state per slot; a stalled output beat holds the final
// push and a tick scan hit while a result is pending; one item is in work at a time
// reset: asynchronous, active low; slot busy bits clear at once, no clearing pass
`default_nettype none

module reliable_chunk_tracker_top #(
  parameter int SLOT_COUNT = rct_pkg::SLOT_COUNT_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] sequence_in
  input  wire  [2:0]  s_axis_tuser,   // [2:0] action
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [2:0] slot, [34:3] sequence_out,
                                      // [38:35] freed_count, [39] zero
  output logic [3:0]  m_axis_tuser,   // [2:0] kind, [3] data_accepted
  output logic        m_axis_tlast,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rct_pkg::rct_cmd_t    cmd;
  rct_pkg::rct_status_t status;

  logic [2:0]  out_kind, out_slot;
  logic [31:0] out_seq;
  logic        out_acc;
  logic [3:0]  out_freed;

  assign pready = 1'b1;

  rct_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rct_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .item_action_i (s_axis_tuser),
    .item_seq_i    (s_axis_tdata),
    .cfg_write_i   (psel && penable && pwrite && pready),
    .cfg_index_i   (paddr[2]),
    .cfg_wdata_i   (pwdata),
    .cfg_rdata_o   (prdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_kind_o    (out_kind),
    .out_slot_o    (out_slot),
    .out_seq_o     (out_seq),
    .out_acc_o     (out_acc),
    .out_freed_o   (out_freed),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_freed, out_seq, out_slot};
  assign m_axis_tuser = {out_acc, out_kind};

endmodule

`default_nettype wire

// ===== design/rct_controller.sv =====
// sequencer that steps the datapath through each action
`default_nettype none

module rct_controller (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  rct_pkg::rct_status_t status_i,
  output rct_pkg::rct_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_EVAL,
    ST_ACK_OUT,
    ST_FINAL
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status_i.action)
          rct_pkg::ACT_OPEN: begin
            cmd_o.do_open = 1'b1;
            state_d       = ST_IDLE;
          end
          rct_pkg::ACT_SEND: begin
            cmd_o.do_send = 1'b1;
            state_d       = ST_FINAL;
          end
          rct_pkg::ACT_TICK: begin
            cmd_o.time_inc   = 1'b1;
            cmd_o.scan_clear = 1'b1;
            state_d          = ST_SCAN_RD;
          end
          rct_pkg::ACT_ACK: begin
            cmd_o.scan_clear = 1'b1;
            state_d          = ST_SCAN_RD;
          end
          rct_pkg::ACT_DATA: begin
            cmd_o.do_data = 1'b1;
            state_d       = ST_FINAL;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SCAN_RD: begin
        cmd_o.scan_read = 1'b1;
        state_d         = ST_SCAN_EVAL;
      end
      ST_SCAN_EVAL: begin
        if (status_i.action == rct_pkg::ACT_TICK) begin
          // a new hit has to push the held result out first
          if (!(status_i.tick_hit && status_i.pend_valid && status_i.out_busy)) begin
            cmd_o.tick_eval = 1'b1;
            if ((status_i.tick_hit && status_i.hits_full) || status_i.scan_last) begin
              state_d = ST_FINAL;
            end else begin
              cmd_o.scan_next = 1'b1;
              state_d         = ST_SCAN_RD;
            end
          end
        end else begin
          cmd_o.ack_eval = 1'b1;
          if (status_i.scan_last) begin
            state_d = ST_ACK_OUT;
          end else begin
            cmd_o.scan_next = 1'b1;
            state_d         = ST_SCAN_RD;
          end
        end
      end
      ST_ACK_OUT: begin
        cmd_o.ack_result = 1'b1;
        state_d          = ST_FINAL;
      end
      ST_FINAL: begin
        if (!status_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (!status_i.out_busy) begin
          cmd_o.finalize = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/rct_datapath.sv =====
// slot table, counters, config registers and result registers
`default_nettype none

module rct_datapath #(
  parameter int SLOT_COUNT = rct_pkg::SLOT_COUNT_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  rct_pkg::rct_cmd_t     cmd_i,
  output rct_pkg::rct_status_t  status_o,
  input  wire  [2:0]            item_action_i,
  input  wire  [31:0]           item_seq_i,
  input  wire                   cfg_write_i,
  input  wire                   cfg_index_i,
  input  wire  [31:0]           cfg_wdata_i,
  output logic [31:0]           cfg_rdata_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic [2:0]            out_kind_o,
  output logic [2:0]            out_slot_o,
  output logic [31:0]           out_seq_o,
  output logic                  out_acc_o,
  output logic [3:0]            out_freed_o,
  output logic                  out_last_o
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [31:0] init_send_q;
  logic [15:0] resend_ivl_q;

  logic [SLOT_COUNT-1:0] busy_q;
  logic [31:0] seq_mem  [SLOT_COUNT];
  logic [31:0] time_mem [SLOT_COUNT];

  logic [31:0] next_send_q, exp_rx_q, last_ack_q, time_q;
  logic        rx_any_q;

  logic [2:0]       act_q;
  logic [31:0]      seq_q;
  logic [IDX_W-1:0] idx_q;
  logic [3:0]       hits_q, freed_q;
  logic [31:0]      rseq_q, rtime_q;

  logic        pend_valid_q;
  logic [2:0]  pend_kind_q, pend_slot_q;
  logic [31:0] pend_seq_q;
  logic        pend_acc_q;
  logic [3:0]  pend_freed_q;

  logic        out_valid_q;
  logic [2:0]  out_kind_q, out_slot_q;
  logic [31:0] out_seq_q;
  logic        out_acc_q, out_last_q;
  logic [3:0]  out_freed_q;

  // lowest free slot
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  logic [31:0] age, ack_diff;
  logic        tick_hit, ack_hit, scan_last, data_ok, push, restamp;

  assign age       = time_q - rtime_q;
  assign tick_hit  = busy_q[idx_q] && (age >= {16'b0, resend_ivl_q});
  // serial order: difference zero or negative
  assign ack_diff  = rseq_q - seq_q;
  assign ack_hit   = busy_q[idx_q] && ((ack_diff == 32'd0) || ack_diff[31]);
  assign scan_last = (idx_q == IDX_W'(SLOT_COUNT - 1));
  assign data_ok   = !rx_any_q || (seq_q == exp_rx_q);
  assign restamp   = cmd_i.tick_eval && tick_hit;
  assign push      = (restamp && pend_valid_q) || cmd_i.finalize;

  assign status_o.action     = act_q;
  assign status_o.tick_hit   = tick_hit;
  assign status_o.hits_full  = (hits_q == 4'(rct_pkg::MAX_RESULTS - 1));
  assign status_o.scan_last  = scan_last;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign cfg_rdata_o = (cfg_index_i == rct_pkg::REG_RESEND_IVL) ?
                       {16'b0, resend_ivl_q} : init_send_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_send_q  <= rct_pkg::INIT_SEND_RST;
      resend_ivl_q <= rct_pkg::RESEND_IVL_RST;
      busy_q       <= '0;
      next_send_q  <= '0;
      exp_rx_q     <= '0;
      last_ack_q   <= '0;
      rx_any_q     <= 1'b0;
      time_q       <= '0;
      act_q        <= '0;
      idx_q        <= '0;
      hits_q       <= '0;
      freed_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_write_i) begin
        if (cfg_index_i == rct_pkg::REG_INIT_SEND) begin
          init_send_q <= cfg_wdata_i;
        end else begin
          resend_ivl_q <= cfg_wdata_i[15:0];
        end
      end
      if (cmd_i.load_item) begin
        act_q <= item_action_i;
      end
      if (cmd_i.do_open) begin
        busy_q      <= '0;
        next_send_q <= init_send_q;
        exp_rx_q    <= '0;
        last_ack_q  <= '0;
        rx_any_q    <= 1'b0;
      end
      if (cmd_i.do_send && free_found) begin
        busy_q[free_idx] <= 1'b1;
        next_send_q      <= next_send_q + 32'd1;
      end
      if (cmd_i.do_data && data_ok) begin
        exp_rx_q   <= seq_q + 32'd1;
        last_ack_q <= seq_q;
        rx_any_q   <= 1'b1;
      end
      if (cmd_i.time_inc) begin
        time_q <= time_q + 32'd1;
      end
      if (cmd_i.scan_clear) begin
        idx_q   <= '0;
        hits_q  <= '0;
        freed_q <= '0;
      end
      if (cmd_i.scan_next) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (restamp) begin
        hits_q <= hits_q + 4'd1;
      end
      if (cmd_i.ack_eval && ack_hit) begin
        busy_q[idx_q] <= 1'b0;
        if (freed_q != 4'd15) begin
          freed_q <= freed_q + 4'd1;
        end
      end
      if (cmd_i.do_send || cmd_i.do_data || cmd_i.ack_result || restamp) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.finalize) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // slot memories, item latch and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      seq_q <= item_seq_i;
    end
    if (cmd_i.do_send && free_found) begin
      seq_mem[free_idx]  <= next_send_q;
      time_mem[free_idx] <= time_q;
    end else if (restamp) begin
      time_mem[idx_q] <= time_q;
    end
    if (cmd_i.scan_read) begin
      rseq_q  <= seq_mem[idx_q];
      rtime_q <= time_mem[idx_q];
    end

    if (cmd_i.do_send) begin
      pend_kind_q  <= free_found ? rct_pkg::KIND_REGISTERED : rct_pkg::KIND_FULL;
      pend_slot_q  <= free_found ? 3'(free_idx) : 3'd0;
      pend_seq_q   <= free_found ? next_send_q : 32'd0;
      pend_acc_q   <= 1'b0;
      pend_freed_q <= 4'd0;
    end else if (cmd_i.do_data) begin
      pend_kind_q  <= data_ok ? rct_pkg::KIND_ACK_ACCEPT : rct_pkg::KIND_ACK_DROP;
      pend_slot_q  <= 3'd0;
      pend_seq_q   <= data_ok ? seq_q : last_ack_q;
      pend_acc_q   <= data_ok;
      pend_freed_q <= 4'd0;
    end else if (cmd_i.ack_result) begin
      pend_kind_q  <= rct_pkg::KIND_ACK_DONE;
      pend_slot_q  <= 3'd0;
      pend_seq_q   <= seq_q;
      pend_acc_q   <= 1'b0;
      pend_freed_q <= freed_q;
    end else if (restamp) begin
      pend_kind_q  <= rct_pkg::KIND_RESEND;
      pend_slot_q  <= 3'(idx_q);
      pend_seq_q   <= rseq_q;
      pend_acc_q   <= 1'b0;
      pend_freed_q <= 4'd0;
    end

    if (push) begin
      out_kind_q  <= pend_kind_q;
      out_slot_q  <= pend_slot_q;
      out_seq_q   <= pend_seq_q;
      out_acc_q   <= pend_acc_q;
      out_freed_q <= pend_freed_q;
      out_last_q  <= cmd_i.finalize;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_slot_o  = out_slot_q;
  assign out_seq_o   = out_seq_q;
  assign out_acc_o   = out_acc_q;
  assign out_freed_o = out_freed_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== design/rct_checker.sv =====
// port-level checks of the chunk tracker, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module rct_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [39:0] m_axis_tdata,
  input wire [3:0]  m_axis_tuser,
  input wire        m_axis_tlast
);

  // a stalled result beat keeps its contents
  `RCT_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  `RCT_ASSERT_IMPL(a_kind_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser[2:0] <= rct_pkg::KIND_ACK_DONE)

  // accept flag only on an in-order data ack
  `RCT_ASSERT_IMPL(a_acc_kind, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser[3] == (m_axis_tuser[2:0] == rct_pkg::KIND_ACK_ACCEPT))

  `RCT_ASSERT_IMPL(a_freed_kind, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser[2:0] != rct_pkg::KIND_ACK_DONE), m_axis_tdata[38:35] == 4'd0)

  // one item at a time: ready drops after each accepted beat
  `RCT_ASSERT(a_ready_drop, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

endmodule

bind reliable_chunk_tracker_top rct_checker u_rct_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the chunk tracker: directed and random items checked against a predictor
`timescale 1ns / 100ps

module tb_top;

  localparam int SLOTS       = rct_pkg::SLOT_COUNT_DEF;
  localparam int SETTLE      = 4 * SLOTS + 8;
  localparam int CYCLE_LIMIT = 400000;

  // actions the block ignores
  localparam logic [2:0] ACT_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] ACT_RESERVED_LAST  = 3'd7;

  typedef struct {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [31:0] seq;
    logic        acc;
    logic [3:0]  freed;
    logic        last;
  } chunk_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  wire         s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] sequence_in
  logic [2:0]  s_axis_tuser;   // [2:0] action
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [39:0] m_axis_tdata;   // [2:0] slot, [34:3] sequence_out, [38:35] freed_count
  wire  [3:0]  m_axis_tuser;   // [2:0] kind, [3] data_accepted
  wire         m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  wire  [31:0] prdata;
  wire         pready;

  // predictor state
  logic        in_flight [SLOTS];
  logic [31:0] slot_num [SLOTS];
  logic [31:0] slot_stamp [SLOTS];
  logic [31:0] send_number;
  logic [31:0] rx_expect;
  logic [31:0] acked_number;
  logic        rx_seen;
  logic [31:0] tick_count;
  logic [31:0] cfg_first_send;
  logic [15:0] cfg_resend_ivl;

  chunk_result_t awaited_results[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  reliable_chunk_tracker_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic logic at_or_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d == 32'd0) || d[31];
  endfunction

  function automatic chunk_result_t make_result(input logic [2:0] kind, input logic [2:0] slot,
                                                input logic [31:0] seq, input logic acc,
                                                input logic [3:0] freed);
    chunk_result_t r;
    r.kind  = kind;
    r.slot  = slot;
    r.seq   = seq;
    r.acc   = acc;
    r.freed = freed;
    r.last  = 1'b0;
    return r;
  endfunction

  task automatic reset_tracker_model();
    for (int i = 0; i < SLOTS; i++) begin
      in_flight[i]  = 1'b0;
      slot_num[i]   = '0;
      slot_stamp[i] = '0;
    end
    send_number    = '0;
    rx_expect      = '0;
    acked_number   = '0;
    rx_seen        = 1'b0;
    tick_count     = '0;
    cfg_first_send = rct_pkg::INIT_SEND_RST;
    cfg_resend_ivl = rct_pkg::RESEND_IVL_RST;
  endtask

  // works out the results of one accepted item and queues them
  task automatic compute_chunk_results(input logic [2:0] action, input logic [31:0] seq);
    chunk_result_t batch[$];
    int            found;
    logic [3:0]    freed;
    found = -1;
    freed = '0;
    case (action)
      rct_pkg::ACT_OPEN: begin
        for (int i = 0; i < SLOTS; i++) in_flight[i] = 1'b0;
        send_number  = cfg_first_send;
        rx_expect    = '0;
        acked_number = '0;
        rx_seen      = 1'b0;
      end
      rct_pkg::ACT_SEND: begin
        for (int i = SLOTS - 1; i >= 0; i--) if (!in_flight[i]) found = i;
        if (found < 0) begin
          batch.push_back(make_result(rct_pkg::KIND_FULL, '0, '0, 1'b0, '0));
        end else begin
          in_flight[found]  = 1'b1;
          slot_num[found]   = send_number;
          slot_stamp[found] = tick_count;
          batch.push_back(make_result(rct_pkg::KIND_REGISTERED, found[2:0], send_number,
                                      1'b0, '0));
          send_number = send_number + 32'd1;
        end
      end
      rct_pkg::ACT_TICK: begin
        tick_count = tick_count + 32'd1;
        for (int i = 0; i < SLOTS && batch.size() < rct_pkg::MAX_RESULTS; i++) begin
          if (in_flight[i] && (tick_count - slot_stamp[i]) >= {16'd0, cfg_resend_ivl}) begin
            slot_stamp[i] = tick_count;
            batch.push_back(make_result(rct_pkg::KIND_RESEND, i[2:0], slot_num[i], 1'b0, '0));
          end
        end
      end
      rct_pkg::ACT_ACK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (in_flight[i] && at_or_before(slot_num[i], seq)) begin
            in_flight[i] = 1'b0;
            if (freed != 4'd15) freed++;
          end
        end
        batch.push_back(make_result(rct_pkg::KIND_ACK_DONE, '0, seq, 1'b0, freed));
      end
      rct_pkg::ACT_DATA: begin
        if (!rx_seen || seq == rx_expect) begin
          rx_expect    = seq + 32'd1;
          acked_number = seq;
          rx_seen      = 1'b1;
          batch.push_back(make_result(rct_pkg::KIND_ACK_ACCEPT, '0, seq, 1'b1, '0));
        end else begin
          batch.push_back(make_result(rct_pkg::KIND_ACK_DROP, '0, acked_number, 1'b0, '0));
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) awaited_results.push_back(batch[k]);
  endtask

  task automatic check_beat();
    chunk_result_t got;
    chunk_result_t want;
    got.kind  = m_axis_tuser[2:0];
    got.acc   = m_axis_tuser[3];
    got.slot  = m_axis_tdata[2:0];
    got.seq   = m_axis_tdata[34:3];
    got.freed = m_axis_tdata[38:35];
    got.last  = m_axis_tlast;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("beat with nothing awaited, kind %0d seq %h", got.kind, got.seq));
      return;
    end
    want = awaited_results.pop_front();
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
    if (got.slot !== want.slot)
      report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
    if (got.seq !== want.seq)
      report_mismatch($sformatf("sequence_out %h, want %h", got.seq, want.seq));
    if (got.acc !== want.acc)
      report_mismatch($sformatf("data_accepted %b, want %b", got.acc, want.acc));
    if (got.freed !== want.freed)
      report_mismatch($sformatf("freed_count %0d, want %0d", got.freed, want.freed));
    if (got.last !== want.last)
      report_mismatch($sformatf("tlast %b, want %b", got.last, want.last));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_beat();
  end

  // sends one item; tvalid stays up after the beat unless a gap follows
  task automatic send_item(input logic [2:0] action, input logic [31:0] seq);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= seq;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    compute_chunk_results(action, seq);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // items without results may still be in work when the queue empties
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_register(input logic reg_idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (reg_idx == rct_pkg::REG_INIT_SEND) cfg_first_send = value;
    else cfg_resend_ivl = value[15:0];
  endtask

  task automatic set_config(input logic [31:0] first_send, input logic [15:0] ivl);
    wait_idle();
    write_register(rct_pkg::REG_INIT_SEND, first_send);
    write_register(rct_pkg::REG_RESEND_IVL, {16'd0, ivl});
  endtask

  // reset state: send runs before any open, numbering from zero
  task automatic test_send_before_open();
    send_item(rct_pkg::ACT_SEND, $urandom);
    send_item(rct_pkg::ACT_SEND, $urandom);
    send_item(rct_pkg::ACT_DATA, 32'd7);
    send_item(rct_pkg::ACT_DATA, 32'd9);
    send_item(rct_pkg::ACT_ACK, 32'd0);
  endtask

  // table full, all slots due on one tick, serial compare across the number wrap
  task automatic test_wrap_and_full();
    set_config(32'hFFFF_FFFE, 16'd1);
    send_item(rct_pkg::ACT_OPEN, 32'hFFFF_FFFF);
    for (int i = 0; i <= SLOTS; i++) send_item(rct_pkg::ACT_SEND, '0);
    send_item(rct_pkg::ACT_TICK, '0);
    send_item(rct_pkg::ACT_ACK, 32'd0);
    send_item(rct_pkg::ACT_TICK, 32'hFFFF_FFFF);
    send_item(rct_pkg::ACT_ACK, 32'd5);
    send_item(rct_pkg::ACT_DATA, 32'hFFFF_FFFF);
    send_item(rct_pkg::ACT_DATA, 32'd0);
    send_item(rct_pkg::ACT_DATA, 32'd0);
    for (int a = ACT_RESERVED_FIRST; a <= ACT_RESERVED_LAST; a++)
      send_item(a[2:0], $urandom);
    send_item(rct_pkg::ACT_OPEN, '0);
  endtask

  task automatic random_item();
    int          pick;
    logic [31:0] seq;
    pick = $urandom_range(99);
    seq  = $urandom;
    if (pick < 30) begin
      send_item(rct_pkg::ACT_SEND, seq);
    end else if (pick < 55) begin
      send_item(rct_pkg::ACT_TICK, seq);
    end else if (pick < 75) begin
      if ($urandom_range(99) < 75) seq = send_number - $urandom_range(SLOTS, 0);
      send_item(rct_pkg::ACT_ACK, seq);
    end else if (pick < 91) begin
      if (rx_seen && $urandom_range(99) < 70) seq = rx_expect;
      else if (rx_seen && $urandom_range(99) < 50) seq = rx_expect - 32'd1;
      send_item(rct_pkg::ACT_DATA, seq);
    end else if (pick < 95) begin
      send_item(rct_pkg::ACT_OPEN, seq);
    end else begin
      send_item(3'($urandom_range(ACT_RESERVED_LAST, ACT_RESERVED_FIRST)), seq);
    end
  endtask

  task automatic random_phase(input int src_idle, input int sink_stall,
                              input logic [31:0] first_send, input logic [15:0] ivl,
                              input int count, input int pause_at);
    set_config(first_send, ivl);
    idle_pct  = src_idle;
    stall_pct = sink_stall;
    send_item(rct_pkg::ACT_OPEN, $urandom);
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) wait_drained();
      random_item();
    end
  endtask

  task automatic test_random_traffic();
    random_phase(0, 0, $urandom, 16'd1, 30, -1);
    random_phase(55, 0, 32'd0, 16'hFFFF, 30, 20);
    random_phase(0, 55, 32'hFFFF_FFFF, 16'($urandom_range(6, 2)), 30, -1);
    random_phase(31, 31, $urandom, 16'($urandom_range(4, 1)), 30, -1);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= rct_pkg::ACT_OPEN;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    reset_tracker_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_send_before_open();
    test_wrap_and_full();
    test_random_traffic();

    wait_idle();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
